// ===== hw/rtl/sms_pkg.sv =====
// sms_pkg: shared widths, codes, command/status types and the coil phase table
// for the stepper move sequencer; used by every module of the block
`default_nettype none

package sms_pkg;

    // clock ticks per second of the tick stream, also the divider dividend
    localparam int TICKS_PER_SECOND = 1000;

    // field widths
    localparam int OP_W    = 1;
    localparam int RATE_W  = 10;
    localparam int POS_W   = 32;
    localparam int COIL_W  = 4;
    localparam int STATE_W = 2;
    localparam int BRAKE_W = 8;
    localparam int PHASE_W = 4;
    localparam int REST_W  = 3;

    // stream word layout, padded to whole bytes
    localparam int IN_FIELDS_W  = RATE_W + POS_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = COIL_W + STATE_W + POS_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_STEP  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_HOLD = 1'd1;
    localparam logic [BRAKE_W-1:0]   BRAKE_RESET    = 8'd10;

    // item kinds
    localparam logic [OP_W-1:0] OP_TICK = 1'b0;
    localparam logic [OP_W-1:0] OP_MOVE = 1'b1;

    // run state codes seen on the result stream
    localparam logic [STATE_W-1:0] RUN_IDLE  = 2'd0;
    localparam logic [STATE_W-1:0] RUN_RUN   = 2'd1;
    localparam logic [STATE_W-1:0] RUN_BRAKE = 2'd2;

    // phase index that drives all coils off
    localparam logic [PHASE_W-1:0] PHASE_OFF = 4'd8;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic div_start;
        logic commit;
    } t_sms_cmd;

    // datapath to controller status
    typedef struct packed {
        logic move_ok;
        logic div_done;
    } t_sms_stat;

    // coil pattern per phase index, bit0 A1, bit1 B1, bit2 A2, bit3 B2
    function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] idx);
        logic [COIL_W-1:0] pat;
        case (idx)
            4'd0: pat = 4'd9;
            4'd1: pat = 4'd1;
            4'd2: pat = 4'd3;
            4'd3: pat = 4'd2;
            4'd4: pat = 4'd6;
            4'd5: pat = 4'd4;
            4'd6: pat = 4'd12;
            4'd7: pat = 4'd8;
            default: pat = 4'd0;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sms_div.sv =====
// sms_div: restoring divider, TICKS_PER_SECOND over the step rate, one
// quotient bit per cycle; depends on sms_pkg
`default_nettype none

module sms_div (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    input  wire [sms_pkg::RATE_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [sms_pkg::RATE_W-1:0]  o_quotient
);
    import sms_pkg::*;

    localparam int CNT_W = $clog2(RATE_W);

    logic [RATE_W-1:0] r_rem, n_rem;
    logic [RATE_W-1:0] r_quo, n_quo;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [RATE_W:0]   trial;
    logic [RATE_W:0]   diff;

    // one restoring step: shift in the next dividend bit, try subtract
    always_comb begin
        trial  = {r_rem, r_quo[RATE_W-1]};
        diff   = trial - {1'b0, i_divisor};
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = RATE_W'(TICKS_PER_SECOND);
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial >= {1'b0, i_divisor}) begin
                n_rem = diff[RATE_W-1:0];
                n_quo = {r_quo[RATE_W-2:0], 1'b1};
            end else begin
                n_rem = trial[RATE_W-1:0];
                n_quo = {r_quo[RATE_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(RATE_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // partial remainder and quotient
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== hw/rtl/sms_dp.sv =====
// sms_dp: sequencer datapath: input latch, config registers, motion state,
// phase stepping and position count; depends on sms_pkg and sms_div
`default_nettype none

module sms_dp (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  sms_pkg::t_sms_cmd             i_cmd,
    output sms_pkg::t_sms_stat            o_stat,
    input  wire                           i_cfg_valid,
    input  wire [sms_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [sms_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire [sms_pkg::OP_W-1:0]       i_op,
    input  wire [sms_pkg::RATE_W-1:0]     i_rate,
    input  wire [sms_pkg::POS_W-1:0]      i_target,
    output logic [sms_pkg::COIL_W-1:0]    o_coil,
    output logic [sms_pkg::STATE_W-1:0]   o_run_state,
    output logic [sms_pkg::POS_W-1:0]     o_position,
    output logic                          o_rejected
);
    import sms_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_RUN   = 3'b010,
        MODE_BRAKE = 3'b100
    } t_mode;

    // latched item
    logic [OP_W-1:0]   r_op;
    logic [RATE_W-1:0] r_rate;
    logic [POS_W-1:0]  r_target;

    // configuration
    logic              r_half_cfg;
    logic [BRAKE_W-1:0] r_brake_cfg;

    // motion state
    t_mode              r_mode, n_mode;
    logic               r_dir_ccw, n_dir_ccw;
    logic               r_step_half, n_step_half;
    logic [RATE_W-1:0]  r_period_reload, n_period_reload;
    logic [RATE_W-1:0]  r_period_count, n_period_count;
    logic [PHASE_W-1:0] r_phase_now, n_phase_now;
    logic [REST_W-1:0]  r_rest_phase, n_rest_phase;
    logic [BRAKE_W-1:0] r_brake_count, n_brake_count;
    logic [POS_W-1:0]   r_position, n_position;
    logic [POS_W-1:0]   r_goal, n_goal;
    logic [COIL_W-1:0]  r_coil, n_coil;
    logic               r_rejected, n_rejected;

    // helpers
    logic               div_done;
    logic [RATE_W-1:0]  quotient;
    logic               move_ok;
    logic [REST_W-1:0]  delta;
    logic [REST_W-1:0]  stepped_phase;
    logic               step_now;
    logic               counts;
    logic [POS_W-1:0]   pos_step;
    logic [POS_W-1:0]   pos_tick;
    logic [RATE_W-1:0]  pc_dec;
    logic [BRAKE_W-1:0] bc_dec;

    sms_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_divisor  (r_rate),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign move_ok = (r_op == OP_MOVE) && (r_rate != '0)
                     && (r_rate <= RATE_W'(TICKS_PER_SECOND));
    assign o_stat.move_ok  = move_ok;
    assign o_stat.div_done = div_done;

    // tick helpers: next phase, step counting and counters
    always_comb begin
        delta         = r_step_half ? REST_W'(1) : REST_W'(2);
        stepped_phase = r_dir_ccw ? (r_phase_now[REST_W-1:0] - delta)
                                  : (r_phase_now[REST_W-1:0] + delta);
        step_now      = (r_period_count == r_period_reload);
        counts        = r_step_half ? !stepped_phase[0] : 1'b1;
        pos_step      = r_dir_ccw ? (r_position - 1'b1) : (r_position + 1'b1);
        pos_tick      = (step_now && counts) ? pos_step : r_position;
        pc_dec        = r_period_count - 1'b1;
        bc_dec        = (r_brake_count != '0) ? (r_brake_count - 1'b1) : r_brake_count;
    end

    // state update on commit
    always_comb begin
        n_mode          = r_mode;
        n_dir_ccw       = r_dir_ccw;
        n_step_half     = r_step_half;
        n_period_reload = r_period_reload;
        n_period_count  = r_period_count;
        n_phase_now     = r_phase_now;
        n_rest_phase    = r_rest_phase;
        n_brake_count   = r_brake_count;
        n_position      = r_position;
        n_goal          = r_goal;
        n_coil          = r_coil;
        n_rejected      = r_rejected;
        if (i_cmd.commit) begin
            n_rejected = 1'b0;
            case (r_op)
                OP_TICK: begin
                    case (r_mode)
                        MODE_RUN: begin
                            if (step_now) begin
                                n_phase_now = {1'b0, stepped_phase};
                                n_coil      = coil_of({1'b0, stepped_phase});
                            end
                            n_position     = pos_tick;
                            n_period_count = (pc_dec == '0) ? r_period_reload : pc_dec;
                            if (r_goal == pos_tick) begin
                                n_mode = MODE_BRAKE;
                            end
                        end
                        MODE_BRAKE: begin
                            n_brake_count = bc_dec;
                            if (bc_dec == '0) begin
                                n_rest_phase = r_phase_now[REST_W-1:0];
                                n_phase_now  = PHASE_OFF;
                                n_coil       = coil_of(PHASE_OFF);
                                n_mode       = MODE_IDLE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                OP_MOVE: begin
                    if (move_ok) begin
                        n_period_reload = quotient;
                        n_period_count  = quotient;
                        n_dir_ccw       = ($signed(r_target) < $signed(r_position));
                        n_goal          = r_target;
                        n_step_half     = r_half_cfg;
                        n_phase_now     = {1'b0, r_rest_phase};
                        n_brake_count   = r_brake_cfg;
                        n_mode          = (r_target == r_position) ? MODE_BRAKE : MODE_RUN;
                    end else begin
                        n_rejected = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op     <= i_op;
            r_rate   <= i_rate;
            r_target <= i_target;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_cfg  <= 1'b0;
            r_brake_cfg <= BRAKE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HALF_STEP:  r_half_cfg  <= i_cfg_data[0];
                CFG_BRAKE_HOLD: r_brake_cfg <= i_cfg_data[BRAKE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // motion state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= MODE_IDLE;
            r_dir_ccw       <= 1'b0;
            r_step_half     <= 1'b0;
            r_period_reload <= RATE_W'(1);
            r_period_count  <= RATE_W'(1);
            r_phase_now     <= PHASE_OFF;
            r_rest_phase    <= '0;
            r_brake_count   <= '0;
            r_position      <= '0;
            r_goal          <= '0;
            r_coil          <= '0;
            r_rejected      <= 1'b0;
        end else begin
            r_mode          <= n_mode;
            r_dir_ccw       <= n_dir_ccw;
            r_step_half     <= n_step_half;
            r_period_reload <= n_period_reload;
            r_period_count  <= n_period_count;
            r_phase_now     <= n_phase_now;
            r_rest_phase    <= n_rest_phase;
            r_brake_count   <= n_brake_count;
            r_position      <= n_position;
            r_goal          <= n_goal;
            r_coil          <= n_coil;
            r_rejected      <= n_rejected;
        end
    end

    // result word comes straight from the state, which holds until the next commit
    always_comb begin
        case (r_mode)
            MODE_RUN:   o_run_state = RUN_RUN;
            MODE_BRAKE: o_run_state = RUN_BRAKE;
            default:    o_run_state = RUN_IDLE;
        endcase
    end

    assign o_coil     = r_coil;
    assign o_position = r_position;
    assign o_rejected = r_rejected;

endmodule

`default_nettype wire

// ===== hw/rtl/sms_ctrl.sv =====
// sms_ctrl: sequencer controller: input handshake, divider launch, commit
// and result valid; depends on sms_pkg
`default_nettype none

module sms_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output sms_pkg::t_sms_cmd   o_cmd,
    input  sms_pkg::t_sms_stat  i_stat
);
    import sms_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_DISPATCH = 4'b0010,
        ST_DIV      = 4'b0100,
        ST_WB       = 4'b1000
    } t_ctrl_state;

    t_ctrl_state r_state, n_state;
    logic        r_out_valid, n_out_valid;
    logic        out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd.load_in   = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.commit    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (i_stat.move_ok) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    n_state = ST_WB;
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // result word valid: set by commit, cleared when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/stepper_move_sequencer.sv =====
// Four-coil stepper move sequencer.
// Input stream: one word per item, tuser is the kind (0 tick, 1 move);
// tdata carries the step rate and the signed target position.
// Output stream: one word per input word with coil pattern, run state,
// position count, and tuser flagging a rejected move.
// Config channel: index 0 selects half-step drive, index 1 the brake hold
// time in ticks; always ready, sampled when a move is committed.
// Sequencing: a tick or rejected move passes from the input latch through a
// dispatch state to the write-back state, where its result is committed; a
// valid move also waits in a divide state for the restoring divider that
// turns the rate into a step period. The next word is taken from the cycle
// after the previous result is committed, so one item is handled at a time.
// The input is taken while an earlier result still waits; the new result
// is committed only once the old one has been taken, so a stalled output
// holds its word and the block waits.
// Reset (synchronous, active low) leaves the motor idle, coils off,
// position 0, full-step drive and a brake hold of 10 ticks.
`default_nettype none

module stepper_move_sequencer (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // input stream
    input  wire                             i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [9:0] step_rate, [41:10] target, [47:42] zero
    input  wire [sms_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // [0] op
    input  wire [sms_pkg::OP_W-1:0]         i_s_axis_tuser,
    // result stream
    output logic                            o_m_axis_tvalid,
    input  wire                             i_m_axis_tready,
    // [3:0] coil_pattern, [5:4] run_state, [37:6] current_position, [39:38] zero
    output logic [sms_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // [0] move_rejected
    output logic                            o_m_axis_tuser,
    // configuration write channel
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire [sms_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [sms_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sms_pkg::*;

    t_sms_cmd           cmd;
    t_sms_stat          stat;
    logic [COIL_W-1:0]  coil;
    logic [STATE_W-1:0] run_state;
    logic [POS_W-1:0]   position;
    logic               rejected;

    sms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    sms_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op        (i_s_axis_tuser),
        .i_rate      (i_s_axis_tdata[RATE_W-1:0]),
        .i_target    (i_s_axis_tdata[RATE_W +: POS_W]),
        .o_coil      (coil),
        .o_run_state (run_state),
        .o_position  (position),
        .o_rejected  (rejected)
    );

    // pack the result word
    assign o_m_axis_tdata = {{OUT_PAD_W{1'b0}}, position, run_state, coil};
    assign o_m_axis_tuser = rejected;
    assign o_cfg_ready    = 1'b1;

endmodule

`default_nettype wire
